### src/polygon_edge_clip_stage_core_assert.svh
// Assertion macros for the polygon edge clip stage.
`ifndef POLYGON_EDGE_CLIP_STAGE_CORE_ASSERT_SVH
`define POLYGON_EDGE_CLIP_STAGE_CORE_ASSERT_SVH
// Antecedent implies consequent on the next clock.
`define PECS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the same clock.
`define PECS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

### src/pecs_pkg.sv
// Package: controller states, commands and status shared by the clip stage.
package pecs_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_SIDE, ST_DIV, ST_LERP, ST_EMIT_X, ST_EMIT_V
  } pecs_state_t;

  typedef struct packed {
    logic load;      // capture input transaction
    logic side;      // side products step
    logic div_start; // initialize divider
    logic div_step;  // one quotient bit
    logic lerp;      // lerp step
  } pecs_cmd_t;

  typedef struct packed {
    logic is_vertex;
    logic ins_e;
    logic ins_s;
    logic side_done;
    logic div_done;
    logic lerp_done;
  } pecs_sts_t;
endpackage

### src/polygon_edge_clip_stage_core.sv
// Top level: one Sutherland-Hodgman clip pass against one edge.
// A seed is only captured; a vertex gets side products and, on a crossing, a divide
// and lerp, then the crossing and (if inside) the vertex are emitted.
// One transaction at a time: input stalls until the controller is idle again; the
// restoring divider yields one quotient bit per cycle, FRAC_BITS+1 bits in all.
// Reset (synchronous, rst_n low): clears edge registers, previous vertex, FSM.
module polygon_edge_clip_stage_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic                          out_is_last
);
  import pecs_pkg::*;

  pecs_cmd_t cmd;
  pecs_sts_t sts;
  logic      sel_vertex;

  // controller sequences side products, divide, lerp and emission
  pecs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sel_vertex, .last(out_is_last), .cmd, .sts
  );

  // datapath holds edge, previous vertex and arithmetic units
  pecs_dp #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .in_req_type,
    .in_vertex_x, .in_vertex_y, .sel_vertex, .res_x(out_x), .res_y(out_y),
    .cmd, .sts
  );
endmodule

### src/pecs_ctrl.sv
// Controller state machine for the clip stage.
module pecs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  sel_vertex,
  output logic                  last,
  output pecs_pkg::pecs_cmd_t   cmd,
  input  pecs_pkg::pecs_sts_t   sts
);
  import pecs_pkg::*;
  `include "polygon_edge_clip_stage_core_assert.svh"

  pecs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    sel_vertex = 1'b0;
    last       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        if (!sts.is_vertex) state_nxt = ST_IDLE;
        else begin
          cmd.side = 1'b1;
          if (sts.side_done) begin
            if (sts.ins_e != sts.ins_s) begin
              cmd.div_start = 1'b1;
              state_nxt = ST_DIV;
            end else if (sts.ins_e) state_nxt = ST_EMIT_V;
            else                    state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_LERP;
      end
      ST_LERP: begin
        cmd.lerp = 1'b1;
        if (sts.lerp_done) state_nxt = ST_EMIT_X;
      end
      ST_EMIT_X: begin
        out_valid = 1'b1;
        last      = !sts.ins_e;
        if (!out_stall) state_nxt = sts.ins_e ? ST_EMIT_V : ST_IDLE;
      end
      ST_EMIT_V: begin
        out_valid  = 1'b1;
        sel_vertex = 1'b1;
        last       = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `PECS_ASSERT_NOW(a_no_accept_busy, state_r != ST_IDLE, in_stall)
  `PECS_ASSERT_NEXT(a_div_follows, state_r == ST_DIV && sts.div_done, state_r == ST_LERP)
  `PECS_ASSERT_NOW(a_vert_inside, state_r == ST_EMIT_V, sts.ins_e)
endmodule

### src/pecs_dp.sv
// Datapath: side products, restoring divider and saturating lerp.
module pecs_dp #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  input  logic                          in_req_type,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic                          sel_vertex,
  output logic signed [COORD_WIDTH-1:0] res_x,
  output logic signed [COORD_WIDTH-1:0] res_y,
  input  pecs_pkg::pecs_cmd_t           cmd,
  output pecs_pkg::pecs_sts_t           sts
);
  import pecs_pkg::*;
  localparam int DW = COORD_WIDTH + 1;     // differences
  localparam int PW = 2 * DW;              // products
  localparam int SW = PW + 1;              // side values
  localparam int QW = FRAC_BITS + 2;       // quotient
  localparam int CW = $clog2(FRAC_BITS + 2);
  localparam int MW = DW + QW;             // lerp product

  logic signed [COORD_WIDTH-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [COORD_WIDTH-1:0] px_r, py_r, vx_r, vy_r;
  logic                          typ_r;
  logic [1:0]                    ph_r;
  logic signed [PW-1:0]          m0_r, m1_r;
  logic signed [SW-1:0]          se_r, ss_r;
  logic [SW-1:0]                 rem_r, dvs_r;
  logic [QW-1:0]                 q_r;
  logic [CW-1:0]                 cnt_r;
  logic signed [COORD_WIDTH-1:0] ox_r, oy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        2'd0: sx_r <= cfg_data;
        2'd1: sy_r <= cfg_data;
        2'd2: ex_r <= cfg_data;
        2'd3: ey_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // phase-muxed operands: one pair of side-product multipliers reused across phases
  logic signed [DW-1:0] ax, ay, dpx, dpy, mdx, mdy, lx;
  logic signed [COORD_WIDTH-1:0] qx, qy;
  logic signed [MW-1:0] lm;
  logic signed [SW-1:0] sd, dd, lv;
  logic [SW-1:0] rsub;
  logic signed [SW-1:0] cmax, cmin;
  logic ins_e, ins_s, prev_upd;
  always_comb begin
    ax  = DW'(ex_r) - DW'(sx_r);
    ay  = DW'(ey_r) - DW'(sy_r);
    qx  = ph_r[0] ? px_r : vx_r;
    qy  = ph_r[0] ? py_r : vy_r;
    dpx = DW'(qx) - DW'(sx_r);
    dpy = DW'(qy) - DW'(sy_r);
    mdx = DW'(vx_r) - DW'(px_r);
    mdy = DW'(vy_r) - DW'(py_r);
    sd  = SW'(m0_r) - SW'(m1_r);
    dd  = ss_r - se_r;
    rsub = rem_r - dvs_r;
    cmax = SW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    cmin = ~cmax;
    lx  = ph_r[0] ? mdy : mdx;
    lm  = MW'(lx) * $signed({1'b0, q_r});
    lv  = SW'(lm >>> FRAC_BITS) + SW'(ph_r[0] ? py_r : px_r);
    ins_e = !se_r[SW-1];
    ins_s = !ss_r[SW-1];
    // vertex becomes previous once sides are known (no crossing) or after the lerp
    prev_upd = (cmd.side && ph_r == 2'd3 && (ins_e == ins_s)) ||
               (cmd.lerp && ph_r == 2'd1);
  end

  // previous vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0;
    end else if (cmd.load && !in_req_type) begin
      px_r <= in_vertex_x; py_r <= in_vertex_y;
    end else if (prev_upd) begin
      px_r <= vx_r; py_r <= vy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      typ_r <= in_req_type;
      ph_r  <= '0;
      if (in_req_type) begin
        vx_r <= in_vertex_x; vy_r <= in_vertex_y;
      end
    end
    if (cmd.side) begin
      // phase 0/1: products for vertex/prev; phase 1/2: capture sides
      m0_r <= PW'(ax) * PW'(dpy);
      m1_r <= PW'(ay) * PW'(dpx);
      if (ph_r == 2'd1) se_r <= sd;
      if (ph_r == 2'd2) ss_r <= sd;
      ph_r <= ph_r + 2'd1;
    end
    if (cmd.div_start) begin
      rem_r <= ss_r[SW-1] ? SW'(-ss_r) : SW'(ss_r);
      dvs_r <= dd[SW-1] ? SW'(-dd) : SW'(dd);
      q_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rsub << 1;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_r << 1;
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.lerp) begin
      ph_r <= ph_r + 2'd1;
      if (ph_r == 2'd0)
        ox_r <= (lv > cmax) ? cmax[COORD_WIDTH-1:0] :
                (lv < cmin) ? cmin[COORD_WIDTH-1:0] : lv[COORD_WIDTH-1:0];
      else
        oy_r <= (lv > cmax) ? cmax[COORD_WIDTH-1:0] :
                (lv < cmin) ? cmin[COORD_WIDTH-1:0] : lv[COORD_WIDTH-1:0];
    end
  end

  always_comb begin
    sts.is_vertex = typ_r;
    sts.ins_e     = ins_e;
    sts.ins_s     = ins_s;
    sts.side_done = (ph_r == 2'd3);
    sts.div_done  = (cnt_r == CW'(FRAC_BITS));
    sts.lerp_done = (ph_r == 2'd1);
    res_x = sel_vertex ? vx_r : ox_r;
    res_y = sel_vertex ? vy_r : oy_r;
  end
endmodule
